// ===== design/integer_to_radix_ascii_unit_assert.svh =====
// assertion macros shared by the design files
`ifndef INTEGER_TO_RADIX_ASCII_UNIT_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ITRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true out of reset
`define ITRA_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ITRA_ASSERT(label, prop, msg)
`define ITRA_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ===== design/itra_pkg.sv =====
package itra_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 64;
    localparam int INPUT_WIDTH         = 64;
    localparam int RADIX_WIDTH         = 6;
    localparam int CHAR_WIDTH          = 7;

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_WIDTH-1:0] DECIMAL_RADIX = 6'd10;

    localparam logic [CHAR_WIDTH-1:0] MINUS_CHAR  = 7'd45;
    localparam logic [CHAR_WIDTH-1:0] ZERO_CHAR   = 7'd48;
    localparam logic [CHAR_WIDTH-1:0] LETTER_CHAR = 7'd65;
    localparam logic [CHAR_WIDTH-1:0] ERROR_CHAR  = 7'd0;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERROR,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_LOAD
    } state_t;

    // request from the sequencer to the divider
    typedef struct packed {
        logic                   start;
        logic [RADIX_WIDTH-1:0] divisor;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // digit value 0..35 to its ascii code
    function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [RADIX_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] r;
        if (d < 6'd10) begin
            r = ZERO_CHAR + {1'b0, d};
        end else begin
            r = LETTER_CHAR + {1'b0, d} - 7'd10;
        end
        return r;
    endfunction

endpackage

// ===== design/itra_in_if.sv =====
interface itra_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [itra_pkg::INPUT_WIDTH-1:0]      value;
    logic [itra_pkg::RADIX_WIDTH-1:0]      radix;
    logic                                  opcode;

    modport source (output valid, output value, output radix, output opcode, input ready);
    modport sink   (input valid, input value, input radix, input opcode, output ready);
endinterface

// ===== design/itra_out_if.sv =====
interface itra_out_if;
    logic                              valid;
    logic                              ready;
    logic [itra_pkg::CHAR_WIDTH-1:0]   character;
    logic                              last;
    logic                              error;

    modport source (output valid, output character, output last, output error, input ready);
    modport sink   (input valid, input character, input last, input error, output ready);
endinterface

// ===== design/itra_divider.sv =====
`include "integer_to_radix_ascii_unit_assert.svh"

// restoring divider, one quotient bit per cycle
module itra_divider #(
    parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  itra_pkg::div_req_t                req,
    input  logic [VALUE_WIDTH-1:0]            dividend,
    output itra_pkg::div_stat_t               stat,
    output logic [VALUE_WIDTH-1:0]            quotient,
    output logic [itra_pkg::RADIX_WIDTH-1:0]  remainder
);

    localparam int CW = $clog2(VALUE_WIDTH);
    localparam int RW = itra_pkg::RADIX_WIDTH;

    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [RW-1:0]          rem_reg, rem_next;
    logic [RW-1:0]          div_reg;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [RW:0] trial;
    logic [RW:0] diff;
    logic        ge;

    always_comb
    begin
        trial = {rem_reg, q_reg[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});
    end

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = CW'(VALUE_WIDTH - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[VALUE_WIDTH-2:0], ge};
            rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (req.start) begin
            div_reg <= req.divisor;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

    `ITRA_ASSERT(a_div_done_idle, done_reg |-> !busy_reg, "divider done while still busy")
    `ITRA_ASSERT(a_div_rem_range, done_reg |-> (rem_reg < div_reg), "remainder not below divisor")
    `ITRA_ASSERT(a_div_start_busy, req.start |=> busy_reg, "divider did not start")

endmodule

// ===== design/integer_to_radix_ascii_unit.sv =====
// integer to ascii conversion in radix 2 to 36
//
// channels: "number" takes one word of value, radix and opcode (0 unsigned,
// 1 signed); "text" returns the characters most significant first, '0'-'9'
// then 'A'-'Z', with last set on the final one. signed negative values in
// radix 10 get a leading '-'. a bad radix, or a signed negative value in any
// radix but 10, returns a single word with error set, character 0, last set.
//
// sequence: each digit costs one pass of the shared restoring divider, whose
// done pulse stores the digit. after the last digit a '-' is loaded if the
// value is negative, then each character takes a store read and a load.
// number.ready is high only between conversions; one item is in work at a time.
//
// reset clears the sequencer state, the divider busy and done flags and the output valid.
// a stall on text holds the output register and the sequencer waits on it.
`include "integer_to_radix_ascii_unit_assert.svh"

module integer_to_radix_ascii_unit #(
    parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    itra_in_if.sink     number,
    itra_out_if.source  text
);

    localparam int IW = $clog2(VALUE_WIDTH);
    localparam int RW = itra_pkg::RADIX_WIDTH;
    localparam int CHW = itra_pkg::CHAR_WIDTH;

    // sequencer state
    itra_pkg::state_t state_reg, state_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             neg_reg, neg_next;
    logic [RW-1:0]    radix_reg, radix_next;

    // divider link
    itra_pkg::div_req_t    div_req;
    itra_pkg::div_stat_t   div_stat;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [RW-1:0]          remainder;

    // digit store, least significant digit at index 0
    logic [RW-1:0] digit_mem [VALUE_WIDTH];
    logic [RW-1:0] rd_data_reg;
    logic          digit_we;

    // output register
    logic           out_valid_reg;
    logic [CHW-1:0] out_char_reg;
    logic           out_last_reg;
    logic           out_err_reg;
    logic           out_free;
    logic           out_load;
    logic [CHW-1:0] out_char;
    logic           out_last;
    logic           out_err;

    // input decode
    logic [VALUE_WIDTH-1:0] value_w;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic                   is_neg;
    logic                   bad_radix;
    logic                   reject;
    logic                   quot_zero;

    always_comb
    begin
        value_w   = number.value[VALUE_WIDTH-1:0];
        is_neg    = (number.opcode == itra_pkg::OP_SIGNED) && value_w[VALUE_WIDTH-1];
        // most negative value wraps to its unsigned magnitude
        magnitude = is_neg ? (~value_w + 1'b1) : value_w;
        bad_radix = (number.radix < itra_pkg::RADIX_MIN) ||
                    (number.radix > itra_pkg::RADIX_MAX);
        reject    = bad_radix || (is_neg && (number.radix != itra_pkg::DECIMAL_RADIX));
    end

    assign out_free  = !out_valid_reg || text.ready;
    assign quot_zero = (quotient == '0);

    itra_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .stat      (div_stat),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itra_pkg::ST_IDLE:
            begin
                if (number.valid) begin
                    state_next = reject ? itra_pkg::ST_ERROR : itra_pkg::ST_DIVIDE;
                end
            end
            itra_pkg::ST_ERROR:
            begin
                if (out_free) begin
                    state_next = itra_pkg::ST_IDLE;
                end
            end
            itra_pkg::ST_DIVIDE:
            begin
                if (div_stat.done && quot_zero) begin
                    state_next = neg_reg ? itra_pkg::ST_SIGN : itra_pkg::ST_READ;
                end
            end
            itra_pkg::ST_SIGN:
            begin
                if (out_free) begin
                    state_next = itra_pkg::ST_READ;
                end
            end
            itra_pkg::ST_READ:
            begin
                state_next = itra_pkg::ST_LOAD;
            end
            itra_pkg::ST_LOAD:
            begin
                if (out_free) begin
                    state_next = (idx_reg == '0) ? itra_pkg::ST_IDLE : itra_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = itra_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        number.ready   = 1'b0;
        div_req.start  = 1'b0;
        div_req.divisor = radix_reg;
        div_dividend   = quotient;
        digit_we       = 1'b0;
        out_load       = 1'b0;
        out_char       = itra_pkg::ERROR_CHAR;
        out_last       = 1'b0;
        out_err        = 1'b0;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        radix_next     = radix_reg;
        case (state_reg)
            itra_pkg::ST_IDLE:
            begin
                number.ready = 1'b1;
                if (number.valid) begin
                    radix_next = number.radix;
                    neg_next   = is_neg;
                    idx_next   = '0;
                    if (!reject) begin
                        div_req.start   = 1'b1;
                        div_req.divisor = number.radix;
                        div_dividend    = magnitude;
                    end
                end
            end
            itra_pkg::ST_ERROR:
            begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_char = itra_pkg::ERROR_CHAR;
                    out_last = 1'b1;
                    out_err  = 1'b1;
                end
            end
            itra_pkg::ST_DIVIDE:
            begin
                // store the remainder digit, divide again while quotient is nonzero
                if (div_stat.done) begin
                    digit_we = 1'b1;
                    if (!quot_zero) begin
                        div_req.start = 1'b1;
                        idx_next      = idx_reg + 1'b1;
                    end
                end
            end
            itra_pkg::ST_SIGN:
            begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_char = itra_pkg::MINUS_CHAR;
                end
            end
            itra_pkg::ST_READ:
            begin
                // store read of digit idx_reg lands in rd_data_reg
            end
            itra_pkg::ST_LOAD:
            begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_char = itra_pkg::digit_to_ascii(rd_data_reg);
                    out_last = (idx_reg == '0);
                    if (idx_reg != '0) begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= itra_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (text.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        neg_reg   <= neg_next;
        radix_reg <= radix_next;
        if (out_load) begin
            out_char_reg <= out_char;
            out_last_reg <= out_last;
            out_err_reg  <= out_err;
        end
    end

    // digit store
    always_ff @(posedge clk)
    begin
        if (digit_we) begin
            digit_mem[idx_reg] <= remainder;
        end
        rd_data_reg <= digit_mem[idx_reg];
    end

    assign text.valid     = out_valid_reg;
    assign text.character = out_char_reg;
    assign text.last      = out_last_reg;
    assign text.error     = out_err_reg;

    `ITRA_ASSERT(a_no_overwrite, out_load |-> (!out_valid_reg || text.ready), "output word overwritten")
    `ITRA_ASSERT(a_start_idle, div_req.start |-> !div_stat.busy, "divider restarted while busy")
    `ITRA_ASSERT(a_error_word, (text.valid && text.error) |-> (text.last && (text.character == itra_pkg::ERROR_CHAR)), "malformed error word")

endmodule
